FILE: hw/rtl/pgs_pkg.sv
`default_nettype none

package pgs_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int unsigned NUM_KW = 6;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_HASH,
    PH_KW,
    PH_CONDSKIP,
    PH_REST
  } phase_e;

  typedef enum logic [2:0] {
    KW_NONE,
    KW_IF,
    KW_IFDEF,
    KW_IFNDEF,
    KW_ELIF,
    KW_ELSE,
    KW_ENDIF
  } kw_e;

  typedef enum logic [2:0] {
    EV_OPEN,
    EV_ELIF,
    EV_ELSE,
    EV_CLOSE,
    EV_CLOSE_EOB
  } ev_e;

  typedef enum logic [1:0] {
    TAG_IF,
    TAG_IFDEF,
    TAG_IFNDEF
  } tag_e;

  // One finished line (or end of buffer) handed from front to back.
  typedef struct packed {
    kw_e  kw;
    logic eob;
  } line_rec_t;

  typedef struct packed {
    ev_e         kind;
    tag_e        tag;
    logic [31:0] line_start;
    logic [31:0] cond_start;
    logic [31:0] line_stop;
    logic        last;
  } res_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_FF) || (b == CH_VT);
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h41 && b <= 8'h5A) || (b == CH_UNDER);
  endfunction

  // Keyword text, byte 0 in the low bits (strings are written reversed).
  function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [47:0] w;
    w = '0;
    case (idx)
      3'd0:    w = 48'("fi");
      3'd1:    w = 48'("fedfi");
      3'd2:    w = 48'("fednfi");
      3'd3:    w = 48'("file");
      3'd4:    w = 48'("esle");
      3'd5:    w = 48'("fidne");
      default: w = '0;
    endcase
    return 8'(w >> {pos, 3'b000});
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] idx);
    logic [2:0] n;
    case (idx)
      3'd0:    n = 3'd2;
      3'd1:    n = 3'd5;
      3'd2:    n = 3'd6;
      3'd3:    n = 3'd4;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pgs_in_if.sv
`default_nettype none

interface pgs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source(output valid, data_byte, end_of_buffer, input ready);
  modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pgs_out_if.sv
`default_nettype none

interface pgs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [1:0]  open_tag;
  logic [31:0] line_start;
  logic [31:0] cond_start;
  logic [31:0] line_stop;
  logic        last_of_run;

  modport source(output valid, event_kind, open_tag, line_start, cond_start, line_stop,
                 last_of_run, input ready);
  modport sink(input valid, event_kind, open_tag, line_start, cond_start, line_stop,
               last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pgs_fifo.sv
`default_nettype none

module pgs_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pgs_front.sv
`default_nettype none

module pgs_front
  import pgs_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  pgs_in_if.sink                      req_i,
  input  wire logic                   full_i,
  output logic                        push_o,
  output line_rec_t                   rec_o,
  output logic      [OFFSET_BITS-1:0] ls_o,
  output logic      [OFFSET_BITS-1:0] cs_o,
  output logic      [OFFSET_BITS-1:0] stop_o
);

  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] lbeg_q, lbeg_d;
  logic [OFFSET_BITS-1:0] cond_q, cond_d;
  phase_e                 phase_q, phase_d;
  logic [NUM_KW-1:0]      cand_q, cand_d;
  logic [2:0]             pos_q, pos_d;
  kw_e                    match_q, match_d;

  logic [OFFSET_BITS-1:0] nxt, cs;
  logic [7:0]             b;
  logic                   nl, eob, accept, run_kw;
  logic [NUM_KW-1:0]      kc, live;
  logic [2:0]             kp;
  kw_e                    mk, kw;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && !full_i;
  assign b           = req_i.data_byte;
  assign eob         = req_i.end_of_buffer;
  assign nl          = (b == CH_NL);
  assign nxt         = off_q + OFFSET_BITS'(1);

  always_comb begin
    off_d   = off_q;
    lbeg_d  = lbeg_q;
    cond_d  = cond_q;
    phase_d = phase_q;
    cand_d  = cand_q;
    pos_d   = pos_q;
    match_d = match_q;
    run_kw  = 1'b0;
    kc      = cand_q;
    kp      = pos_q;
    live    = '0;
    mk      = KW_NONE;
    kw      = KW_NONE;
    cs      = '0;

    case (phase_q)
      PH_LEAD: begin
        if (b == CH_HASH) begin
          phase_d = PH_HASH;
        end else if (!is_blank(b) && !nl) begin
          phase_d = PH_REST;
        end
      end
      PH_HASH: begin
        if (!is_blank(b) && !nl) begin
          phase_d = PH_KW;
          cand_d  = '1;
          pos_d   = 3'd0;
          kc      = '1;
          kp      = 3'd0;
          run_kw  = 1'b1;
        end
      end
      PH_KW: begin
        run_kw = 1'b1;
      end
      PH_CONDSKIP: begin
        if (is_blank(b)) begin
          cond_d = nxt;
        end else begin
          phase_d = PH_REST;
        end
      end
      default: begin
      end
    endcase

    // Keyword matcher: all candidates advance on the same byte.
    if (run_kw) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (kc[i]) begin
          if (kp < kw_len(3'(i))) begin
            live[i] = (b == kw_char(3'(i), kp));
          end else if (kp == kw_len(3'(i)) && !is_word(b)) begin
            mk = kw_e'(3'(i + 1));
          end
        end
      end
      if (mk != KW_NONE) begin
        match_d = mk;
        if (is_blank(b)) begin
          cond_d  = nxt;
          phase_d = PH_CONDSKIP;
        end else begin
          cond_d  = off_q;
          phase_d = PH_REST;
        end
      end else if (live == '0) begin
        phase_d = PH_REST;
      end else begin
        cand_d = live;
        pos_d  = (kp < 3'd7) ? kp + 3'd1 : kp;
      end
    end

    // Line end: a keyword still open at buffer end counts if complete.
    kw = match_d;
    cs = cond_d;
    if (phase_d == PH_KW && match_d == KW_NONE) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (cand_d[i] && pos_d == kw_len(3'(i))) begin
          kw = kw_e'(3'(i + 1));
        end
      end
      cs = nxt;
    end

    off_d = nxt;
    if (nl || eob) begin
      phase_d = PH_LEAD;
      cand_d  = '1;
      pos_d   = 3'd0;
      match_d = KW_NONE;
      cond_d  = '0;
      lbeg_d  = nxt;
    end
    if (eob) begin
      off_d  = '0;
      lbeg_d = '0;
    end
  end

  assign push_o    = accept && (nl || eob);
  assign rec_o.kw  = kw;
  assign rec_o.eob = eob;
  assign ls_o      = lbeg_q;
  assign cs_o      = cs;
  assign stop_o    = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      lbeg_q  <= '0;
      cond_q  <= '0;
      phase_q <= PH_LEAD;
      cand_q  <= '1;
      pos_q   <= 3'd0;
      match_q <= KW_NONE;
    end else if (accept) begin
      off_q   <= off_d;
      lbeg_q  <= lbeg_d;
      cond_q  <= cond_d;
      phase_q <= phase_d;
      cand_q  <= cand_d;
      pos_q   <= pos_d;
      match_q <= match_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pgs_back.sv
`default_nettype none

module pgs_back
  import pgs_pkg::*;
#(
  parameter int unsigned OFFSET_BITS    = 32,
  parameter int unsigned MAX_NEST_DEPTH = 255
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   avail_i,
  input  wire line_rec_t              rec_i,
  input  wire logic [OFFSET_BITS-1:0] ls_i,
  input  wire logic [OFFSET_BITS-1:0] cs_i,
  input  wire logic [OFFSET_BITS-1:0] stop_i,
  output logic                        pop_o,
  pgs_out_if.source                   rsp_o
);

  localparam int unsigned DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NEST_DEPTH);

  logic               ig_q, ig_d;
  tag_e               tag_q, tag_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               ovalid_q;
  res_t               out_q;
  logic               pend_q;
  res_t               pend_res_q;

  logic [OFFSET_BITS+31:0] ls_w, cs_w, stop_w;
  logic [31:0] ls32, cs32, stop32;
  logic        first_v, second_v, is_open, slot_free;
  res_t        first, second;
  tag_e        tag_new, open_tag;

  assign ls_w   = {32'd0, ls_i};
  assign cs_w   = {32'd0, cs_i};
  assign stop_w = {32'd0, stop_i};
  assign ls32   = ls_w[31:0];
  assign cs32   = cs_w[31:0];
  assign stop32 = stop_w[31:0];

  assign slot_free = !ovalid_q || rsp_o.ready;
  assign pop_o     = avail_i && !pend_q && slot_free;

  assign is_open = (rec_i.kw == KW_IF) || (rec_i.kw == KW_IFDEF) || (rec_i.kw == KW_IFNDEF);

  always_comb begin
    case (rec_i.kw)
      KW_IFDEF:  open_tag = TAG_IFDEF;
      KW_IFNDEF: open_tag = TAG_IFNDEF;
      default:   open_tag = TAG_IF;
    endcase
  end

  always_comb begin
    ig_d     = ig_q;
    depth_d  = depth_q;
    tag_new  = tag_q;
    first_v  = 1'b0;
    second_v = 1'b0;
    first    = '{kind: EV_OPEN, tag: TAG_IF, line_start: ls32, cond_start: cs32,
                 line_stop: stop32, last: 1'b1};

    if (is_open) begin
      if (!ig_q) begin
        ig_d    = 1'b1;
        depth_d = '0;
        tag_new = open_tag;
        first_v = 1'b1;
      end else if (depth_q < DEPTH_MAX) begin
        depth_d = depth_q + DEPTH_W'(1);
      end
    end else if (ig_q && rec_i.kw == KW_ENDIF) begin
      if (depth_q != '0) begin
        depth_d = depth_q - DEPTH_W'(1);
      end else begin
        first_v          = 1'b1;
        first.kind       = EV_CLOSE;
        first.cond_start = '0;
        ig_d             = 1'b0;
      end
    end else if (ig_q && depth_q == '0 && rec_i.kw == KW_ELIF) begin
      first_v    = 1'b1;
      first.kind = EV_ELIF;
    end else if (ig_q && depth_q == '0 && rec_i.kw == KW_ELSE) begin
      first_v          = 1'b1;
      first.kind       = EV_ELSE;
      first.cond_start = '0;
    end
    first.tag = tag_new;

    second = '{kind: EV_CLOSE_EOB, tag: tag_new, line_start: stop32, cond_start: 32'd0,
               line_stop: stop32, last: 1'b1};
    tag_d  = tag_new;
    if (rec_i.eob) begin
      second_v = ig_d;
      ig_d     = 1'b0;
      depth_d  = '0;
      tag_d    = TAG_IF;
    end
    if (first_v && second_v) begin
      first.last = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ig_q     <= 1'b0;
      tag_q    <= TAG_IF;
      depth_q  <= '0;
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        ig_q    <= ig_d;
        tag_q   <= tag_d;
        depth_q <= depth_d;
      end
      if (slot_free) begin
        if (pend_q) begin
          ovalid_q <= 1'b1;
          pend_q   <= 1'b0;
        end else begin
          ovalid_q <= pop_o && (first_v || second_v);
          pend_q   <= pop_o && first_v && second_v;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (pend_q) begin
        out_q <= pend_res_q;
      end else if (first_v) begin
        out_q <= first;
      end else begin
        out_q <= second;
      end
      pend_res_q <= second;
    end
  end

  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.event_kind  = out_q.kind;
  assign rsp_o.open_tag    = out_q.tag;
  assign rsp_o.line_start  = out_q.line_start;
  assign rsp_o.cond_start  = out_q.cond_start;
  assign rsp_o.line_stop   = out_q.line_stop;
  assign rsp_o.last_of_run = out_q.last;

endmodule

`default_nettype wire

FILE: hw/rtl/preprocessor_conditional_group_scanner_unit.sv
// Conditional group scanner for preprocessor source text.
// req_i takes one source byte per request, with end_of_buffer on the final
// byte of a buffer. rsp_o gives group events for the outermost conditional
// group: open, elif arm, else arm, endif close, and close at end of buffer,
// each with the line start, condition start and line stop offsets.
// Throughput: one byte per cycle while the line queue has room. A byte may
// cause up to two events (open, elif or else, then close at end of buffer on
// the last line); the second goes out once the first is taken, and last_of_run
// marks a byte's final event. Events pass the queue, then the output register.
// The front keeps the per-line keyword match and offsets, a two-entry queue
// holds finished lines, and the back tracks group depth and drives the output
// register. When rsp_o stalls, the queue fills and req_i.ready drops after two
// more line-ending bytes; bytes that end no line are still taken while the
// queue has room.
// Reset clears all offsets and group state; no event is pending after reset.
// After an end_of_buffer byte all offsets and group state return to their reset values.
`default_nettype none

module preprocessor_conditional_group_scanner_unit
  import pgs_pkg::*;
#(
  parameter int unsigned OFFSET_BITS    = 32,
  parameter int unsigned MAX_NEST_DEPTH = 255
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pgs_in_if.sink    req_i,
  pgs_out_if.source rsp_o
);

  localparam int unsigned QW = $bits(line_rec_t) + 3 * OFFSET_BITS;

  logic                   push, pop, full, empty;
  line_rec_t              f_rec, b_rec;
  logic [OFFSET_BITS-1:0] f_ls, f_cs, f_stop, b_ls, b_cs, b_stop;
  logic [QW-1:0]          q_wdata, q_rdata;

  pgs_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .req_i,
    .full_i(full),
    .push_o(push),
    .rec_o (f_rec),
    .ls_o  (f_ls),
    .cs_o  (f_cs),
    .stop_o(f_stop)
  );

  assign q_wdata = {f_rec, f_ls, f_cs, f_stop};

  pgs_fifo #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .wdata_i(q_wdata),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .full_o (full),
    .empty_o(empty)
  );

  assign {b_rec, b_ls, b_cs, b_stop} = q_rdata;

  pgs_back #(
    .OFFSET_BITS   (OFFSET_BITS),
    .MAX_NEST_DEPTH(MAX_NEST_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .avail_i(!empty),
    .rec_i  (b_rec),
    .ls_i   (b_ls),
    .cs_i   (b_cs),
    .stop_i (b_stop),
    .pop_o  (pop),
    .rsp_o
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pgs_checker.sv
`default_nettype none

module pgs_checker
  import pgs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  event_kind_i,
  input wire logic [31:0] line_start_i,
  input wire logic [31:0] cond_start_i,
  input wire logic [31:0] line_stop_i,
  input wire logic        last_of_run_i
);

  // A stalled event stays valid and holds its kind, line stop and last_of_run.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(event_kind_i) && $stable(line_stop_i) && $stable(last_of_run_i))
    else $error("event dropped or changed while stalled");

  // The second event of a byte follows right after the first.
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i |=> out_valid_i)
    else $error("event run broken");

  // Close at end of buffer is always the last of its run, at the buffer length.
  a_eob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == EV_CLOSE_EOB |->
      last_of_run_i && line_start_i == line_stop_i)
    else $error("bad close at end of buffer");

  // Arms without a condition carry a zero condition offset.
  a_nocond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EV_ELSE || event_kind_i == EV_CLOSE ||
                    event_kind_i == EV_CLOSE_EOB) |-> cond_start_i == 32'd0)
    else $error("condition offset on an arm without condition");

  // Event kinds stay within the defined codes.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_kind_i <= EV_CLOSE_EOB)
    else $error("undefined event kind");

endmodule

bind preprocessor_conditional_group_scanner_unit pgs_checker u_pgs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .event_kind_i (rsp_o.event_kind),
  .line_start_i (rsp_o.line_start),
  .cond_start_i (rsp_o.cond_start),
  .line_stop_i  (rsp_o.line_stop),
  .last_of_run_i(rsp_o.last_of_run)
);

`default_nettype wire

FILE: sim/pgs_event_check.sv
`default_nettype none

module pgs_event_check
  import pgs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pgs_in_if           req_mon,
  pgs_out_if          rsp_mon,
  output int unsigned fail_count,
  output int unsigned events_pending,
  output int unsigned events_checked
);

  localparam int unsigned NEST_CAP = 255;

  // Scanner state, kept in step with every accepted byte request.
  logic [31:0] cur_off;
  logic [31:0] line_base;
  logic [31:0] cond_off;
  phase_e      phase;
  logic [5:0]  live_kw;
  logic [2:0]  kw_pos;
  kw_e         found_kw;
  logic        in_grp;
  tag_e        grp_tag;
  logic [7:0]  depth;

  res_t group_events_q[$];

  function automatic string kw_word(input int idx);
    string w;
    case (idx)
      0:       w = "if";
      1:       w = "ifdef";
      2:       w = "ifndef";
      3:       w = "elif";
      4:       w = "else";
      default: w = "endif";
    endcase
    return w;
  endfunction

  function automatic logic is_space_char(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_FF || b == CH_VT;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
           (b >= "A" && b <= "Z") || b == CH_UNDER;
  endfunction

  task automatic clear_line();
    phase    = PH_LEAD;
    live_kw  = '1;
    kw_pos   = '0;
    found_kw = KW_NONE;
    cond_off = '0;
  endtask

  task automatic clear_scan();
    cur_off   = '0;
    line_base = '0;
    in_grp    = 1'b0;
    grp_tag   = TAG_IF;
    depth     = '0;
    clear_line();
  endtask

  task automatic add_event(input ev_e k, input logic [31:0] ls, input logic [31:0] cs,
                           input logic [31:0] le);
    res_t ev;
    ev.kind       = k;
    ev.tag        = grp_tag;
    ev.line_start = ls;
    ev.cond_start = cs;
    ev.line_stop  = le;
    ev.last       = 1'b0;
    group_events_q.insert(group_events_q.size(), ev);
  endtask

  task automatic match_keyword(input logic [7:0] b, input logic [31:0] o);
    logic [5:0] still_live;
    string      w;
    still_live = '0;
    for (int i = 0; i < 6; i++) begin
      if (live_kw[i]) begin
        w = kw_word(i);
        if (kw_pos < w.len()) begin
          if (b == w[kw_pos]) still_live[i] = 1'b1;
        end else if (kw_pos == w.len() && !is_ident_char(b)) begin
          found_kw = kw_e'(i + 1);
        end
      end
    end
    if (found_kw != KW_NONE) begin
      if (is_space_char(b)) begin
        cond_off = o + 1;
        phase    = PH_CONDSKIP;
      end else begin
        cond_off = o;
        phase    = PH_REST;
      end
    end else if (still_live == '0) begin
      phase = PH_REST;
    end else begin
      live_kw = still_live;
      if (kw_pos < 7) kw_pos++;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eob);
    logic [31:0] o;
    logic [31:0] nxt;
    logic [31:0] cs;
    logic        nl;
    kw_e         kw;
    int unsigned before_cnt;
    string       w;
    res_t        tail;
    before_cnt = group_events_q.size();
    nl  = (b == CH_NL);
    o   = cur_off;
    nxt = cur_off + 1;

    case (phase)
      PH_LEAD: begin
        if (b == CH_HASH) phase = PH_HASH;
        else if (!is_space_char(b) && !nl) phase = PH_REST;
      end
      PH_HASH: begin
        if (!is_space_char(b) && !nl) begin
          phase   = PH_KW;
          live_kw = '1;
          kw_pos  = '0;
          match_keyword(b, o);
        end
      end
      PH_KW: match_keyword(b, o);
      PH_CONDSKIP: begin
        if (is_space_char(b)) cond_off = nxt;
        else phase = PH_REST;
      end
      default: ;
    endcase

    if (nl || eob) begin
      kw = found_kw;
      cs = cond_off;
      // buffer ended right on a complete keyword
      if (phase == PH_KW && kw == KW_NONE) begin
        for (int i = 0; i < 6; i++) begin
          w = kw_word(i);
          if (live_kw[i] && kw_pos == w.len()) kw = kw_e'(i + 1);
        end
        cs = nxt;
      end
      if (kw == KW_IF || kw == KW_IFDEF || kw == KW_IFNDEF) begin
        if (!in_grp) begin
          in_grp  = 1'b1;
          depth   = '0;
          grp_tag = tag_e'(kw - KW_IF);
          add_event(EV_OPEN, line_base, cs, nxt);
        end else if (depth < NEST_CAP) begin
          depth++;
        end
      end else if (in_grp && kw == KW_ENDIF) begin
        if (depth > 0) begin
          depth--;
        end else begin
          add_event(EV_CLOSE, line_base, '0, nxt);
          in_grp = 1'b0;
        end
      end else if (in_grp && depth == 0 && kw == KW_ELIF) begin
        add_event(EV_ELIF, line_base, cs, nxt);
      end else if (in_grp && depth == 0 && kw == KW_ELSE) begin
        add_event(EV_ELSE, line_base, '0, nxt);
      end
      clear_line();
      line_base = nxt;
    end
    cur_off = nxt;

    if (eob) begin
      if (in_grp) add_event(EV_CLOSE_EOB, nxt, '0, nxt);
      clear_scan();
    end
    if (group_events_q.size() > before_cnt) begin
      tail = group_events_q[group_events_q.size() - 1];
      tail.last = 1'b1;
      group_events_q[group_events_q.size() - 1] = tail;
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      clear_scan();
      group_events_q.delete();
      fail_count     = 0;
      events_checked = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) scan_byte(req_mon.data_byte, req_mon.end_of_buffer);
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (group_events_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected event, expected none, actual kind %0d line_start %0d",
                   $time, rsp_mon.event_kind, rsp_mon.line_start);
        end else begin
          want = group_events_q.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(rsp_mon.event_kind));
          check_field("open_tag", 32'(want.tag), 32'(rsp_mon.open_tag));
          check_field("line_start", want.line_start, rsp_mon.line_start);
          check_field("cond_start", want.cond_start, rsp_mon.cond_start);
          check_field("line_stop", want.line_stop, rsp_mon.line_stop);
          check_field("last_of_run", 32'(want.last), 32'(rsp_mon.last_of_run));
          events_checked++;
        end
      end
    end
    events_pending = group_events_q.size();
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb
  import pgs_pkg::*;
();

  localparam int unsigned RANDOM_BYTES = 1075;
  localparam int unsigned NEST_OPENS   = 40;
  localparam logic [7:0]  CH_CR        = 8'h0D;

  logic clk_i;
  logic rst_ni;

  pgs_in_if  req_if ();
  pgs_out_if rsp_if ();

  int unsigned fail_count;
  int unsigned events_pending;
  int unsigned events_checked;
  int unsigned bytes_sent   = 0;
  int unsigned buffers_sent = 0;
  int unsigned profile      = 0;
  logic [7:0]  text_q[$];

  preprocessor_conditional_group_scanner_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pgs_event_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .fail_count     (fail_count),
    .events_pending (events_pending),
    .events_checked (events_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver stalls: 55% first, then 22%, then never
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= ((profile == 0) ? 55 : (profile == 1) ? 22 : 0));
    end
  end

  function automatic logic [7:0] blank_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0:       c = CH_SPACE;
      1:       c = CH_TAB;
      2:       c = CH_FF;
      default: c = CH_VT;
    endcase
    return c;
  endfunction

  task automatic add_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = (profile == 0) ? 22 : (profile == 1) ? 55 : 0;
    while ($urandom_range(99) < gap) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.data_byte     <= b;
    req_if.end_of_buffer <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    bytes_sent++;
    profile <= (bytes_sent < 515) ? 0 : (bytes_sent < 1030) ? 1 : 2;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    if (text_q.size() != 0) buffers_sent++;
    text_q.delete();
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned n_lines;
    int unsigned sel;
    int unsigned start_cnt;
    int unsigned k;
    string       word;

    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.data_byte     <= '0;
    req_if.end_of_buffer <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray arm outside any group
    add_text("#elif\n");
    send_buffer();
    // blank lead, blank after '#', CR inside the condition, endif closing at buffer end
    add_char(CH_VT);
    add_text("# ifdef");
    add_char(CH_TAB);
    add_text("c");
    add_char(CH_CR);
    add_text("\n#else\n#endif");
    send_buffer();
    // keyword ends on the last byte: open and close-at-end on one request
    add_text("#if");
    send_buffer();
    add_char(8'h00);
    add_char(8'hFF);
    send_buffer();

    // deep nesting: only the outermost open and the matching last endif report
    for (int i = 0; i < NEST_OPENS; i++) add_text("#if\n");
    for (int i = 0; i < NEST_OPENS; i++) add_text("#endif\n");
    send_buffer();

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      n_lines = $urandom_range(12, 1);
      for (int l = 0; l < n_lines; l++) begin
        sel = $urandom_range(99);
        if (sel < 60) begin
          repeat ($urandom_range(2)) add_char(blank_char());
          add_char(CH_HASH);
          repeat ($urandom_range(2)) add_char(blank_char());
          k = $urandom_range(99);
          if (k < 14) word = "if";
          else if (k < 24) word = "ifdef";
          else if (k < 34) word = "ifndef";
          else if (k < 48) word = "elif";
          else if (k < 62) word = "else";
          else if (k < 90) word = "endif";
          else begin
            case ($urandom_range(4))
              0:       word = "i";
              1:       word = "elifx";
              2:       word = "endif_";
              3:       word = "ifnde";
              default: word = "e1se";
            endcase
          end
          add_text(word);
          k = $urandom_range(9);
          if (k == 0) begin
            // word character right after the keyword kills the match
            case ($urandom_range(2))
              0:       add_char(CH_UNDER);
              1:       add_char(8'($urandom_range("9", "0")));
              default: add_char(8'($urandom_range("z", "a")));
            endcase
          end else if (k < 6) begin
            repeat ($urandom_range(2)) add_char(blank_char());
            repeat ($urandom_range(6)) add_char(8'($urandom_range(126, 33)));
          end
        end else if (sel < 85) begin
          repeat ($urandom_range(10)) add_char(8'($urandom_range(126, 32)));
        end else begin
          repeat ($urandom_range(6, 1)) add_char(8'($urandom_range(255)));
        end
        if (l != n_lines - 1 || $urandom_range(3) != 0) add_char(CH_NL);
      end
      start_cnt = bytes_sent;
      send_buffer();
      random_sent += bytes_sent - start_cnt;
    end

    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (events_pending != 0);
    repeat (8) @(posedge clk_i);

    $display("Scanned %0d bytes in %0d buffers: directed lines, a deep nesting run and",
             bytes_sent, buffers_sent);
    $display("random directive streams under three flow-control profiles; %0d events checked.",
             events_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
